// ===== hw/rtl/acma_pkg.sv =====
// Shared constants and types for the ADC code moving average block.
package acma_pkg;

	localparam int unsigned CODE_W              = 24;
	localparam int unsigned CONV_W              = 2;
	localparam int unsigned WINDOW_LENGTH_DEF   = 16;
	localparam int unsigned CONVERTER_COUNT_DEF = 3;

	typedef enum logic {
		OP_SAMPLE  = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

endpackage

// ===== hw/rtl/acma_in_if.sv =====
// Input channel: one converter word or slot restart per handshake.
interface acma_in_if;
	logic                                valid;
	logic                                ready;
	acma_pkg::op_t                       op;
	logic [acma_pkg::CONV_W-1:0]         converter;
	logic                                input_select;
	logic [acma_pkg::CODE_W-1:0]         raw_code;

	modport source (output valid, op, converter, input_select, raw_code, input ready);
	modport sink   (input valid, op, converter, input_select, raw_code, output ready);
endinterface

// ===== hw/rtl/acma_out_if.sv =====
// Output channel: held average and its valid flag per handshake.
interface acma_out_if;
	logic                        valid;
	logic                        ready;
	logic [acma_pkg::CODE_W-1:0] average;
	logic                        average_valid;

	modport source (output valid, average, average_valid, input ready);
	modport sink   (input valid, average, average_valid, output ready);
endinterface

// ===== hw/rtl/acma_window_ram.sv =====
// Sample window storage: one port, read-old-data on write, registered read.
module acma_window_ram #(
	parameter int unsigned ADDR_W = 7
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           addr,
	input  logic [acma_pkg::CODE_W-1:0] wdata,
	output logic [acma_pkg::CODE_W-1:0] rdata
);

	localparam int unsigned DEPTH = 1 << ADDR_W;

	logic [acma_pkg::CODE_W-1:0] mem [DEPTH];
	logic [acma_pkg::CODE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= mem[addr];
			if (we) begin
				mem[addr] <= wdata;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/acma_recip_div.sv =====
// Floor division of the window sum by the window length via reciprocal multiply.
module acma_recip_div #(
	parameter int unsigned WINDOW_LENGTH = acma_pkg::WINDOW_LENGTH_DEF,
	parameter int unsigned SUM_W         = acma_pkg::CODE_W + $clog2(WINDOW_LENGTH)
) (
	input  logic [SUM_W-1:0]            sum,
	output logic [acma_pkg::CODE_W-1:0] quotient
);

	localparam int unsigned SHIFT      = SUM_W + $clog2(WINDOW_LENGTH);
	localparam int unsigned RECIP_W    = SUM_W + 1;
	localparam int unsigned PROD_W     = SUM_W + RECIP_W;
	localparam logic [63:0] POW        = 64'd1 << SHIFT;
	localparam logic [63:0] RECIP_FULL =
		(POW + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	logic [PROD_W-1:0] product;

	// m = ceil(2^SHIFT / L) is exact for every sum below 2^SUM_W
	assign product  = PROD_W'(sum) * PROD_W'(RECIP);
	assign quotient = product[SHIFT +: acma_pkg::CODE_W];

endmodule

// ===== hw/rtl/adc_code_moving_average.sv =====
// An input word is registered in stages 1, 2 and 3 and then in the output register.
// Throughput: one word per clock while the output is not stalled, back to back, also to the same slot; slot
// count/pointer are touched only in stage 1 and the running sums only in stage 2.
// Divide by the window length is a reciprocal multiply registered at the output.
// Reset clears fill counts, pointers, running sums and the stage and output valids at once;
// the window RAM is not cleared and needs no clearing pass.
module adc_code_moving_average #(
	parameter int unsigned WINDOW_LENGTH   = acma_pkg::WINDOW_LENGTH_DEF,
	parameter int unsigned CONVERTER_COUNT = acma_pkg::CONVERTER_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	acma_in_if.sink     sample,
	acma_out_if.source  result
);

	localparam int unsigned CODE_W     = acma_pkg::CODE_W;
	localparam int unsigned SLOT_COUNT = 2 * CONVERTER_COUNT;
	localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
	localparam int unsigned IDX_W      = $clog2(WINDOW_LENGTH);
	localparam int unsigned CNT_W      = $clog2(WINDOW_LENGTH + 1);
	localparam int unsigned SUM_W      = CODE_W + IDX_W;
	localparam int unsigned ADDR_W     = SLOT_W + IDX_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LENGTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);

	// handshake chain
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic adv1, adv2;

	// stage 1
	logic              v_s1;
	acma_pkg::op_t     op_s1;
	logic              oob_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [CODE_W-1:0] code_s1;

	logic [CNT_W-1:0]  fill_q [SLOT_COUNT];
	logic [IDX_W-1:0]  ptr_q  [SLOT_COUNT];

	logic [CNT_W-1:0]  fill_cur;
	logic [CNT_W-1:0]  fill_nxt;
	logic [IDX_W-1:0]  ptr_cur;
	logic              full_cur;
	logic              full_after;
	logic [IDX_W-1:0]  wr_idx;
	logic              samp_s1;
	logic              in_oob;

	// stage 2
	logic              v_s2;
	logic              samp_s2;
	logic              rst_s2;
	logic              repl_s2;
	logic              fullo_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic [CODE_W-1:0] code_s2;
	logic [CODE_W-1:0] old_code;

	logic [SUM_W-1:0]  sum_q [SLOT_COUNT];
	logic [SUM_W-1:0]  sum_nxt;
	logic [CODE_W-1:0] old_term;

	// stage 3
	logic              v_s3;
	logic              avgv_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [CODE_W-1:0] quot;

	// output register
	logic              out_v_q;
	logic [CODE_W-1:0] avg_q;
	logic              avgv_q;

	assign rdy_out      = !out_v_q || result.ready;
	assign rdy_s3       = !v_s3 || rdy_out;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample.ready = rdy_s1;
	assign adv1         = v_s1 && rdy_s2;
	assign adv2         = v_s2 && rdy_s3;

	assign in_oob = 32'(sample.converter) >= CONVERTER_COUNT;

	// ---------------- stage 1: slot state, window RAM access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			op_s1   <= sample.op;
			oob_s1  <= in_oob;
			slot_s1 <= SLOT_W'({sample.converter, sample.input_select});
			code_s1 <= {~sample.raw_code[CODE_W-1], sample.raw_code[CODE_W-2:0]};
		end
	end

	assign fill_cur   = fill_q[slot_s1];
	assign ptr_cur    = ptr_q[slot_s1];
	assign full_cur   = fill_cur == FULL_CNT;
	assign fill_nxt   = fill_cur + CNT_W'(1);
	assign full_after = full_cur || (fill_nxt == FULL_CNT);
	assign wr_idx     = full_cur ? ptr_cur : fill_cur[IDX_W-1:0];
	assign samp_s1    = !oob_s1 && (op_s1 == acma_pkg::OP_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				fill_q[i] <= '0;
				ptr_q[i]  <= '0;
			end
		end else if (adv1 && !oob_s1) begin
			unique case (op_s1)
				acma_pkg::OP_RESTART: begin
					fill_q[slot_s1] <= '0;
					ptr_q[slot_s1]  <= '0;
				end
				acma_pkg::OP_SAMPLE: begin
					if (full_cur) begin
						ptr_q[slot_s1] <= (ptr_cur == LAST_IDX) ? '0 : ptr_cur + IDX_W'(1);
					end else begin
						fill_q[slot_s1] <= fill_nxt;
					end
				end
				default: begin
				end
			endcase
		end
	end

	acma_window_ram #(
		.ADDR_W (ADDR_W)
	) u_window (
		.clk   (clk),
		.en    (adv1),
		.we    (samp_s1),
		.addr  ({slot_s1, wr_idx}),
		.wdata (code_s1),
		.rdata (old_code)
	);

	// ---------------- stage 2: running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			samp_s2  <= samp_s1;
			rst_s2   <= !oob_s1 && (op_s1 == acma_pkg::OP_RESTART);
			repl_s2  <= full_cur;
			fullo_s2 <= samp_s1 && full_after;
			slot_s2  <= slot_s1;
			code_s2  <= code_s1;
		end
	end

	assign old_term = repl_s2 ? old_code : '0;
	assign sum_nxt  = sum_q[slot_s2] + SUM_W'(code_s2) - SUM_W'(old_term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				sum_q[i] <= '0;
			end
		end else if (adv2) begin
			if (samp_s2) begin
				sum_q[slot_s2] <= sum_nxt;
			end else if (rst_s2) begin
				sum_q[slot_s2] <= '0;
			end
		end
	end

	// ---------------- stage 3: divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			avgv_s3 <= fullo_s2;
			sum_s3  <= sum_nxt;
		end
	end

	acma_recip_div #(
		.WINDOW_LENGTH (WINDOW_LENGTH),
		.SUM_W         (SUM_W)
	) u_div (
		.sum      (sum_s3),
		.quotient (quot)
	);

	// ---------------- output register; not-valid words always carry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			avg_q  <= avgv_s3 ? quot : '0;
			avgv_q <= avgv_s3;
		end
	end

	assign result.valid         = out_v_q;
	assign result.average       = avg_q;
	assign result.average_valid = avgv_q;

	// ---------------- assertions
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.average_valid |-> result.average == '0)
		else $error("not-valid word carries a nonzero average");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> v_s1 && v_s2 && v_s3 && out_v_q)
		else $error("input stalled with a free stage");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !oob_s1 |-> fill_cur <= FULL_CNT)
		else $error("fill count beyond window length");

	a_replace_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && samp_s2 && repl_s2 |-> fullo_s2)
		else $error("replacing word not marked valid");

endmodule
